// File: rtl/core/bagf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bagf_pkg
// Shared constants, types and state codes for the bitmap gap finder.
// ----------------------------------------------------------------------------
package bagf_pkg;

    localparam int LEAF_WORD_COUNT = 1024;
    localparam int LEAF_AW         = $clog2(LEAF_WORD_COUNT);
    localparam int OFF_W           = LEAF_AW + 6;
    localparam int HW              = 48;

    localparam logic [1:0] CMD_MARK = 2'd0;
    localparam logic [1:0] CMD_TEST = 2'd1;
    localparam logic [1:0] CMD_LIST = 2'd2;

    typedef struct packed {
        logic               rd_en;
        logic [LEAF_AW-1:0] rd_addr;
        logic               wr_en;
        logic [LEAF_AW-1:0] wr_addr;
        logic [63:0]        wr_data;
    } leaf_req_t;

    typedef struct packed {
        logic               rd_en;
        logic [LEAF_AW-1:0] rd_addr;
        logic               wr_en;
        logic [LEAF_AW-1:0] wr_addr;
        logic               wr_data;
    } flag_req_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_CHK,
        ST_MK_WR,
        ST_MK_UPL,
        ST_MK_UPF,
        ST_TS_BIT,
        ST_LS_RCHK,
        ST_LS_DREQ,
        ST_LS_DDEC,
        ST_LS_BASE,
        ST_LS_LIM,
        ST_LS_MASK,
        ST_LS_SCAN,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/bitmap_and_tree_gap_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_and_tree_gap_finder
// Presence bitmap with a tree of full flags; mark, test and list-missing.
//
// Requests enter on in_valid/in_stall (cmd, height); results leave on
// out_valid/out_stall. base_height is written through cfg_wr_en/cfg_wr_data.
// One request is worked at a time; in_stall is low only when idle.
// Test reads the leaf word and takes its bit. Mark writes the leaf word, then
// updates the full flag of each tree level above the leaf level, a walk of
// read-modify-writes through the flag memory's read and write ports. List reads
// the root, descends level by level (request, then decode), builds the gap
// mask, then gives one result per cycle while out_stall is low, up to 64.
// After reset a clearing pass over all LEAF_WORD_COUNT addresses zeroes both
// memories; in_stall stays high during it, config writes are still taken.
// A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module bitmap_and_tree_gap_finder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [bagf_pkg::HW-1:0] cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [bagf_pkg::HW-1:0] height,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [bagf_pkg::HW-1:0] out_height,
    output logic                    present,
    output logic                    none_missing,
    output logic                    range_error,
    output logic                    last
);
    import bagf_pkg::*;

    state_t state_reg, state_next;

    logic [LEAF_AW-1:0] clr_reg, clr_next;
    logic [HW-1:0]      base_reg;
    logic [HW-1:0]      max_reg, max_next;
    logic               any_reg, any_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [HW-1:0]      h_reg, h_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [LEAF_AW-1:0] node_reg, node_next;
    logic               own_reg, own_next;
    logic               lchild_leaf_reg, lchild_leaf_next;
    logic [LEAF_AW-1:0] w_reg, w_next;
    logic [HW:0]        first_reg, first_next;
    logic               lim_ok_reg, lim_ok_next;
    logic [5:0]         lim_reg, lim_next;
    logic [63:0]        mask_reg, mask_next;

    logic [HW-1:0]      res_h_reg, res_h_next;
    logic               res_pres_reg, res_pres_next;
    logic               res_none_reg, res_none_next;
    logic               res_rerr_reg, res_rerr_next;

    logic               ov_reg, ov_next;
    logic [HW-1:0]      oh_reg, oh_next;
    logic               op_reg, op_next;
    logic               on_reg, on_next;
    logic               oe_reg, oe_next;
    logic               ol_reg, ol_next;

    leaf_req_t   leaf_req;
    flag_req_t   flag_req;
    logic [63:0] leaf_rdata;
    logic        flag_rdata;

    logic          slot_free;
    logic [HW:0]   off_full;
    logic          in_rng;
    logic [63:0]   leaf_set;
    logic          sib_full;
    logic [LEAF_AW:0] child;
    logic [LEAF_AW:0] chosen;
    logic          left_full;
    logic [HW+1:0] diff;
    logic [5:0]    first_idx;
    logic [63:0]   mask_rest;
    logic [63:0]   therm;

    bagf_mem u_mem (
        .clk        (clk),
        .leaf_req   (leaf_req),
        .flag_req   (flag_req),
        .leaf_rdata (leaf_rdata),
        .flag_rdata (flag_rdata)
    );

    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign off_full  = {1'b0, h_reg} - {1'b0, base_reg};
    assign in_rng    = !off_full[HW] && (off_full[HW-1:OFF_W] == '0);
    assign leaf_set  = leaf_rdata | (64'd1 << off_reg[5:0]);
    assign sib_full  = own_reg && (leaf_rdata == '1);
    assign child     = {node_reg, 1'b0};
    assign left_full = lchild_leaf_reg ? (leaf_rdata == '1) : flag_rdata;
    assign chosen    = left_full ? (child | (LEAF_AW+1)'(1)) : child;
    assign diff      = {2'b00, max_reg} - {1'b0, first_reg};
    assign mask_rest = mask_reg & (mask_reg - 64'd1);

    always_comb
    begin
        first_idx = '0;
        for (int j = 63; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                first_idx = 6'(j);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 64; j++)
        begin
            therm[j] = (6'(j) <= lim_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_reg == LEAF_AW'(LEAF_WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                case (cmd_reg)
                    CMD_MARK: state_next = in_rng ? ST_MK_WR : ST_EMIT;
                    CMD_TEST: state_next = in_rng ? ST_TS_BIT : ST_EMIT;
                    CMD_LIST: state_next = ST_LS_RCHK;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_MK_WR:   state_next = ST_MK_UPL;
            ST_MK_UPL,
            ST_MK_UPF:
            begin
                if (node_reg == LEAF_AW'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MK_UPF;
                end
            end
            ST_TS_BIT:  state_next = ST_EMIT;
            ST_LS_RCHK:
            begin
                if (!any_reg || flag_rdata)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LS_DREQ;
                end
            end
            ST_LS_DREQ: state_next = ST_LS_DDEC;
            ST_LS_DDEC:
            begin
                if (chosen[LEAF_AW])
                begin
                    state_next = ST_LS_BASE;
                end
                else
                begin
                    state_next = ST_LS_DREQ;
                end
            end
            ST_LS_BASE: state_next = ST_LS_LIM;
            ST_LS_LIM:  state_next = ST_LS_MASK;
            ST_LS_MASK:
            begin
                if ((~leaf_rdata & therm & {64{lim_ok_reg}}) == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LS_SCAN;
                end
            end
            ST_LS_SCAN:
            begin
                if (slot_free && (mask_rest == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        clr_next         = clr_reg;
        max_next         = max_reg;
        any_next         = any_reg;
        cmd_next         = cmd_reg;
        h_next           = h_reg;
        off_next         = off_reg;
        node_next        = node_reg;
        own_next         = own_reg;
        lchild_leaf_next = lchild_leaf_reg;
        w_next           = w_reg;
        first_next       = first_reg;
        lim_ok_next      = lim_ok_reg;
        lim_next         = lim_reg;
        mask_next        = mask_reg;
        res_h_next       = res_h_reg;
        res_pres_next    = res_pres_reg;
        res_none_next    = res_none_reg;
        res_rerr_next    = res_rerr_reg;
        ov_next          = ov_reg && out_stall;
        oh_next          = oh_reg;
        op_next          = op_reg;
        on_next          = on_reg;
        oe_next          = oe_reg;
        ol_next          = ol_reg;
        leaf_req         = '0;
        flag_req         = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                leaf_req.wr_en   = 1'b1;
                leaf_req.wr_addr = clr_reg;
                flag_req.wr_en   = 1'b1;
                flag_req.wr_addr = clr_reg;
                clr_next         = clr_reg + LEAF_AW'(1);
            end
            ST_IDLE:
            begin
                cmd_next = cmd;
                h_next   = height;
            end
            ST_CHK:
            begin
                off_next         = off_full[OFF_W-1:0];
                leaf_req.rd_en   = 1'b1;
                leaf_req.rd_addr = off_full[OFF_W-1:6];
                flag_req.rd_en   = 1'b1;
                flag_req.rd_addr = LEAF_AW'(1);
                res_h_next       = h_reg;
                res_pres_next    = 1'b0;
                res_none_next    = 1'b0;
                res_rerr_next    = !in_rng;
            end
            ST_MK_WR:
            begin
                leaf_req.wr_en   = 1'b1;
                leaf_req.wr_addr = off_reg[OFF_W-1:6];
                leaf_req.wr_data = leaf_set;
                leaf_req.rd_en   = 1'b1;
                leaf_req.rd_addr = off_reg[OFF_W-1:6] ^ LEAF_AW'(1);
                own_next         = (leaf_set == '1);
                node_next        = LEAF_AW'({1'b1, off_reg[OFF_W-1:6]} >> 1);
                if (!any_reg || (h_reg > max_reg))
                begin
                    max_next = h_reg;
                end
                any_next = 1'b1;
            end
            ST_MK_UPL,
            ST_MK_UPF:
            begin
                flag_req.wr_en   = 1'b1;
                flag_req.wr_addr = node_reg;
                flag_req.wr_data = (state_reg == ST_MK_UPL) ? sib_full
                                                            : (own_reg && flag_rdata);
                own_next         = flag_req.wr_data;
                flag_req.rd_en   = 1'b1;
                flag_req.rd_addr = node_reg ^ LEAF_AW'(1);
                node_next        = node_reg >> 1;
            end
            ST_TS_BIT:
            begin
                res_pres_next = leaf_rdata[off_reg[5:0]];
            end
            ST_LS_RCHK:
            begin
                res_h_next    = '0;
                res_rerr_next = 1'b0;
                res_none_next = 1'b1;
                node_next     = LEAF_AW'(1);
            end
            ST_LS_DREQ:
            begin
                lchild_leaf_next = child[LEAF_AW];
                leaf_req.rd_en   = child[LEAF_AW];
                leaf_req.rd_addr = child[LEAF_AW-1:0];
                flag_req.rd_en   = !child[LEAF_AW];
                flag_req.rd_addr = child[LEAF_AW-1:0];
            end
            ST_LS_DDEC:
            begin
                node_next        = chosen[LEAF_AW-1:0];
                w_next           = chosen[LEAF_AW-1:0];
                leaf_req.rd_en   = chosen[LEAF_AW];
                leaf_req.rd_addr = chosen[LEAF_AW-1:0];
            end
            ST_LS_BASE:
            begin
                first_next = {1'b0, base_reg} + (HW+1)'({w_reg, 6'd0});
            end
            ST_LS_LIM:
            begin
                lim_ok_next = !diff[HW+1];
                lim_next    = (diff[HW:6] != '0) ? 6'd63 : diff[5:0];
            end
            ST_LS_MASK:
            begin
                mask_next = ~leaf_rdata & therm & {64{lim_ok_reg}};
            end
            ST_LS_SCAN:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    oh_next   = first_reg[HW-1:0] + HW'(first_idx);
                    op_next   = 1'b0;
                    on_next   = 1'b0;
                    oe_next   = 1'b0;
                    ol_next   = (mask_rest == '0);
                    mask_next = mask_rest;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    oh_next = res_h_reg;
                    op_next = res_pres_reg;
                    on_next = res_none_reg;
                    oe_next = res_rerr_reg;
                    ol_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            base_reg  <= '0;
            max_reg   <= '0;
            any_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            max_reg  <= max_next;
            any_reg  <= any_next;
            ov_reg   <= ov_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        h_reg           <= h_next;
        off_reg         <= off_next;
        node_reg        <= node_next;
        own_reg         <= own_next;
        lchild_leaf_reg <= lchild_leaf_next;
        w_reg           <= w_next;
        first_reg       <= first_next;
        lim_ok_reg      <= lim_ok_next;
        lim_reg         <= lim_next;
        res_h_reg       <= res_h_next;
        res_pres_reg    <= res_pres_next;
        res_none_reg    <= res_none_next;
        res_rerr_reg    <= res_rerr_next;
        oh_reg          <= oh_next;
        op_reg          <= op_next;
        on_reg          <= on_next;
        oe_reg          <= oe_next;
        ol_reg          <= ol_next;
    end

    assign out_valid    = ov_reg;
    assign out_height   = oh_reg;
    assign present      = op_reg;
    assign none_missing = on_reg;
    assign range_error  = oe_reg;
    assign last         = ol_reg;

    // no results while the memories are being cleared
    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR |-> !ov_reg)
        else $error("result during clearing pass");

    // a read-modify-write never reads the entry it writes in the same cycle
    a_leaf_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (leaf_req.wr_en && leaf_req.rd_en) |-> leaf_req.wr_addr != leaf_req.rd_addr)
        else $error("leaf read and write collide");

    a_flag_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_req.wr_en && flag_req.rd_en) |-> flag_req.wr_addr != flag_req.rd_addr)
        else $error("flag read and write collide");

    // the scan only runs while gaps remain
    a_scan_mask: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LS_SCAN |-> mask_reg != '0)
        else $error("scan with empty gap mask");

    // the last list result ends the scan
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LS_SCAN && slot_free && mask_rest == '0) |=> ol_reg && ov_reg)
        else $error("scan ended without a last result");

endmodule

// File: rtl/core/bagf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bagf_mem
// Leaf word memory and full flag memory, one read and one write port each,
// read data registered.
// ----------------------------------------------------------------------------
module bagf_mem (
    input  logic                clk,
    input  bagf_pkg::leaf_req_t leaf_req,
    input  bagf_pkg::flag_req_t flag_req,
    output logic [63:0]         leaf_rdata,
    output logic                flag_rdata
);
    import bagf_pkg::*;

    logic [63:0] leaf_mem [LEAF_WORD_COUNT];
    logic        flag_mem [LEAF_WORD_COUNT];

    always_ff @(posedge clk)
    begin
        if (leaf_req.wr_en)
        begin
            leaf_mem[leaf_req.wr_addr] <= leaf_req.wr_data;
        end
        if (leaf_req.rd_en)
        begin
            leaf_rdata <= leaf_mem[leaf_req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_req.wr_en)
        begin
            flag_mem[flag_req.wr_addr] <= flag_req.wr_data;
        end
        if (flag_req.rd_en)
        begin
            flag_rdata <= flag_mem[flag_req.rd_addr];
        end
    end

endmodule

// File: tb/sv/bagf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bagf_checker
// Watches the request and result channels of the gap finder, keeps its own
// copy of the bitmap, tree flags and base height, predicts the results of
// every accepted request and compares them in order with the block's output.
// ----------------------------------------------------------------------------
module bagf_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [bagf_pkg::HW-1:0] cfg_wr_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [bagf_pkg::HW-1:0] height,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [bagf_pkg::HW-1:0] out_height,
    input  logic                    present,
    input  logic                    none_missing,
    input  logic                    range_error,
    input  logic                    last,
    output int                      errors,
    output int                      pending,
    output int                      results_seen
);
    import bagf_pkg::*;

    typedef struct packed {
        logic [HW-1:0] h;
        logic          pres;
        logic          none;
        logic          rerr;
        logic          lst;
    } gap_result_t;

    logic [63:0]   leaf_mem [LEAF_WORD_COUNT];
    bit            flag_mem [LEAF_WORD_COUNT-1];
    logic [HW-1:0] top_mark;
    bit            seen_mark;
    logic [HW-1:0] base_h;
    gap_result_t   gap_buf [256];
    int            head;
    int            tail;

    assign pending = tail - head;

    function automatic bit node_full(longint unsigned n);
        if (n >= LEAF_WORD_COUNT)
            return leaf_mem[n - LEAF_WORD_COUNT] == '1;
        if (n == 0)
            return 0;
        return flag_mem[n - 1];
    endfunction

    function automatic gap_result_t mk(logic [HW-1:0] h, bit p, bit nm, bit re, bit l);
        gap_result_t r;
        r.h    = h;
        r.pres = p;
        r.none = nm;
        r.rerr = re;
        r.lst  = l;
        return r;
    endfunction

    task automatic queue_result(gap_result_t r);
        gap_buf[8'(tail)] = r;
        tail++;
    endtask

    task automatic predict_request(logic [1:0] c, logic [HW-1:0] h);
        longint unsigned off;
        longint unsigned n;
        longint unsigned w;
        longint unsigned first;
        longint unsigned cand;
        bit              inr;
        int              k;
        off = longint'(h) - longint'(base_h);
        inr = (h >= base_h) && (off < LEAF_WORD_COUNT * 64);
        case (c)
            CMD_MARK, CMD_TEST:
            begin
                if (!inr)
                    queue_result(mk(h, 0, 0, 1, 1));
                else if (c == CMD_TEST)
                    queue_result(mk(h, leaf_mem[off >> 6][off[5:0]], 0, 0, 1));
                else
                begin
                    if (!seen_mark || h > top_mark)
                        top_mark = h;
                    seen_mark = 1;
                    w = off >> 6;
                    leaf_mem[w][off[5:0]] = 1'b1;
                    n = (w + LEAF_WORD_COUNT) >> 1;
                    while (n >= 1)
                    begin
                        flag_mem[n - 1] = node_full(2 * n) && node_full(2 * n + 1);
                        n = n >> 1;
                    end
                    queue_result(mk(h, 0, 0, 0, 1));
                end
            end
            CMD_LIST:
            begin
                if (!seen_mark || node_full(1))
                    queue_result(mk('0, 0, 1, 0, 1));
                else
                begin
                    n = 1;
                    k = 0;
                    while (n < LEAF_WORD_COUNT)
                        n = node_full(2 * n) ? 2 * n + 1 : 2 * n;
                    w = n - LEAF_WORD_COUNT;
                    first = longint'(base_h) + w * 64;
                    for (int i = 0; i < 64; i++)
                    begin
                        cand = first + i;
                        if (cand > top_mark)
                            break;
                        if (!leaf_mem[w][i])
                        begin
                            queue_result(mk(cand[HW-1:0], 0, 0, 0, 0));
                            k++;
                        end
                    end
                    if (k == 0)
                        queue_result(mk('0, 0, 1, 0, 1));
                    else
                        gap_buf[8'(tail - 1)].lst = 1;
                end
            end
            default:;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gap_result_t got;
        gap_result_t want;
        if (!rst_n)
        begin
            foreach (leaf_mem[i]) leaf_mem[i] = '0;
            foreach (flag_mem[i]) flag_mem[i] = 0;
            top_mark     = '0;
            seen_mark    = 0;
            base_h       = '0;
            errors       = 0;
            results_seen = 0;
            head         = 0;
            tail         = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = mk(out_height, present, none_missing, range_error, last);
                results_seen++;
                if (tail == head)
                begin
                    $display("%0t: unexpected result h=%h p=%b nm=%b re=%b l=%b", $time,
                             got.h, got.pres, got.none, got.rerr, got.lst);
                    errors++;
                end
                else
                begin
                    want = gap_buf[8'(head)];
                    head++;
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected h=%h p=%b nm=%b re=%b l=%b", $time,
                                 want.h, want.pres, want.none, want.rerr, want.lst);
                        $display("%0t:          actual   h=%h p=%b nm=%b re=%b l=%b", $time,
                                 got.h, got.pres, got.none, got.rerr, got.lst);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_request(cmd, height);
            if (cfg_wr_en)
                base_h = cfg_wr_data;
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bitmap gap finder: directed marks, tests and lists at the
// edges of the range, then random phases under several base heights with
// random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import bagf_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT = 5000;

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic [HW-1:0] cfg_wr_data;
    logic          in_valid;
    logic          in_stall;
    logic [1:0]    cmd;
    logic [HW-1:0] height;
    logic          out_valid;
    logic          out_stall;
    logic [HW-1:0] out_height;
    logic          present;
    logic          none_missing;
    logic          range_error;
    logic          last;

    int            errors;
    int            pending;
    int            results_seen;
    int            requests_sent;
    int            idle_cycles;
    bit            hold_req;
    bit            no_gaps;
    logic [HW-1:0] cur_base;

    bitmap_and_tree_gap_finder dut (.*);

    bagf_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    task automatic send_request(logic [1:0] c, logic [HW-1:0] h);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge clk) in_valid = 0;
        @(negedge clk);
        in_valid = 1;
        cmd      = c;
        height   = h;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    task automatic drain_and_set_base(logic [HW-1:0] b);
        @(negedge clk) in_valid = 0;
        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1;
        cfg_wr_data = b;
        cur_base    = b;
        @(negedge clk) cfg_wr_en = 0;
    endtask

    task automatic random_request();
        int            r;
        logic [63:0]   h;
        r = $urandom_range(0, 99);
        h = {$urandom, $urandom};
        if (r < 40)
            send_request(CMD_MARK, cur_base + HW'($urandom_range(0, 191)));
        else if (r < 60)
            send_request(CMD_TEST, cur_base + HW'($urandom_range(0, 191)));
        else if (r < 80)
            send_request(CMD_LIST, h[HW-1:0]);
        else if (r < 88)
            send_request(r[0] ? CMD_MARK : CMD_TEST, h[HW-1:0]);
        else if (r < 95)
            send_request(r[0] ? CMD_MARK : CMD_TEST,
                         cur_base - HW'(1) - HW'($urandom_range(0, 3)));
        else if (r < 97)
            send_request(CMD_MARK, cur_base + HW'(65535) - HW'($urandom_range(0, 2)));
        else
            send_request(CMD_NOP, h[HW-1:0]);
    endtask

    // result side: random stalls, one long hold when asked
    initial
    begin
        int gap;
        bit held;
        held      = 0;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                @(negedge clk) out_stall = 1;
                repeat (400) @(negedge clk);
                held = 1;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            repeat (gap) @(negedge clk) out_stall = 1;
            @(negedge clk) out_stall = 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 0;
        cfg_wr_en     = 0;
        cfg_wr_data   = '0;
        in_valid      = 0;
        cmd           = CMD_MARK;
        height        = '0;
        requests_sent = 0;
        hold_req      = 0;
        no_gaps       = 0;
        cur_base      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed
        send_request(CMD_LIST, '0);
        send_request(CMD_TEST, '0);
        send_request(CMD_MARK, '0);
        send_request(CMD_LIST, '1);
        send_request(CMD_MARK, 48'd5);
        send_request(CMD_LIST, '0);
        send_request(CMD_TEST, 48'd5);
        send_request(CMD_TEST, 48'd4);
        send_request(CMD_MARK, 48'd65535);
        send_request(CMD_MARK, 48'd65536);
        send_request(CMD_MARK, '1);
        send_request(CMD_TEST, '1);
        send_request(CMD_NOP, 48'hAAAA_5555_AAAA);
        send_request(CMD_LIST, '0);
        drain_and_set_base(48'd100);
        send_request(CMD_TEST, 48'd100);
        send_request(CMD_MARK, 48'd99);
        send_request(CMD_TEST, 48'd165);
        send_request(CMD_LIST, '0);
        drain_and_set_base('0);

        // fill the first leaf word so the descent moves on
        no_gaps = 1;
        for (int i = 0; i < 64; i++)
            send_request(CMD_MARK, 48'(i));
        no_gaps = 0;
        send_request(CMD_LIST, '0);
        send_request(CMD_MARK, 48'd64 + HW'($urandom_range(1, 60)));
        hold_req = 1;
        repeat (6) send_request(CMD_LIST, '0);
        repeat (20) random_request();

        drain_and_set_base('1);
        send_request(CMD_MARK, '1);
        send_request(CMD_LIST, '0);
        repeat (12) random_request();

        drain_and_set_base({16'($urandom_range(0, 65535)), $urandom});
        repeat (16) random_request();

        drain_and_set_base(48'hFFFF_FFFF_0000);
        no_gaps = 1;
        repeat (10) random_request();
        no_gaps = 0;
        repeat (10) random_request();

        @(negedge clk) in_valid = 0;
        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        $display("tb: %0d requests under 5 base settings, %0d results checked",
                 requests_sent, results_seen);
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
